// ===== hw/rtl/tsa_pkg.sv =====
// ----------------------------------------------------------------------------
// tsa_pkg
// Types, codes and zone helpers shared by the track sector allocator.
// ----------------------------------------------------------------------------
package tsa_pkg;

   localparam int MAX_TRACKS_DEFAULT  = 42;
   localparam int MAX_SECTORS_DEFAULT = 21;

   // fixed item field widths
   localparam int FUNC_W   = 2;
   localparam int TRACK_W  = 6;
   localparam int SECTOR_W = 5;
   localparam int STATUS_W = 2;
   localparam int CODE_W   = 2;
   localparam int IL_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;
   localparam int PASS_W   = 2;

   // directory track and its upper neighbor
   localparam logic [TRACK_W-1:0] DIR_TRACK   = 6'd18;
   localparam logic [TRACK_W-1:0] UPPER_FIRST = 6'd19;
   // first-block probe order helpers: 18-d <-> 18+d
   localparam logic [TRACK_W-1:0] MIRROR_SUM  = 6'd36;
   localparam logic [TRACK_W-1:0] MIRROR_NEXT = 6'd35;
   localparam logic [TRACK_W-1:0] MIRROR_LAST = 6'd34;

   // speed zones
   localparam logic [TRACK_W-1:0]  ZONE0_LAST = 6'd17;
   localparam logic [TRACK_W-1:0]  ZONE1_LAST = 6'd24;
   localparam logic [TRACK_W-1:0]  ZONE2_LAST = 6'd30;
   localparam logic [SECTOR_W-1:0] ZONE0_SECTORS = 5'd21;
   localparam logic [SECTOR_W-1:0] ZONE1_SECTORS = 5'd19;
   localparam logic [SECTOR_W-1:0] ZONE2_SECTORS = 5'd18;
   localparam logic [SECTOR_W-1:0] ZONE3_SECTORS = 5'd17;

   // function codes
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FIRST = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_NEXT  = 2'd2;

   // sector status codes
   localparam logic [CODE_W-1:0] STATUS_FREE     = 2'd0;
   localparam logic [CODE_W-1:0] STATUS_USED     = 2'd1;
   localparam logic [CODE_W-1:0] STATUS_RESERVED = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_INTERLEAVE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CONSIDER_RSV = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TRACK_COUNT = 2'd2;

   localparam logic [IL_W-1:0]    INTERLEAVE_RESET  = 5'd1;
   localparam logic               CONSIDER_RSV_RESET = 1'b0;
   localparam logic [TRACK_W-1:0] TRACK_COUNT_RESET = 6'd35;

   // search passes of a next-block request
   localparam logic [PASS_W-1:0] PASS_NEAR  = 2'd0;
   localparam logic [PASS_W-1:0] PASS_OTHER = 2'd1;
   localparam logic [PASS_W-1:0] PASS_LAST  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_PASS,
      ST_CHECK,
      ST_TAKE,
      ST_RESULT
   } tsa_state_type;

   typedef struct packed {
      logic               en;
      logic [TRACK_W-1:0] addr;
   } map_access_type;

   function automatic logic [SECTOR_W-1:0] sectors_on(input logic [TRACK_W-1:0] t,
                                                     input int unsigned max_sectors);
      logic [SECTOR_W-1:0] n;
      if (t <= ZONE0_LAST) begin
         n = ZONE0_SECTORS;
      end else if (t <= ZONE1_LAST) begin
         n = ZONE1_SECTORS;
      end else if (t <= ZONE2_LAST) begin
         n = ZONE2_SECTORS;
      end else begin
         n = ZONE3_SECTORS;
      end
      if (32'(n) > max_sectors) begin
         n = max_sectors[SECTOR_W-1:0];
      end
      return n;
   endfunction

   function automatic logic track_exists(input logic [TRACK_W-1:0] t,
                                         input logic [TRACK_W-1:0] count,
                                         input int unsigned max_tracks);
      return (t != '0) && (t <= count) && (32'(t) <= max_tracks);
   endfunction

endpackage

// ===== hw/rtl/tsa_map_mem.sv =====
// ----------------------------------------------------------------------------
// tsa_map_mem
// Sector status map: one word per track, registered read, valid bit per track
// so that a track never written reads as all sectors free.
// ----------------------------------------------------------------------------
module tsa_map_mem #(
   parameter int DEPTH = tsa_pkg::MAX_TRACKS_DEFAULT + 1,
   parameter int WIDTH = 2 * tsa_pkg::MAX_SECTORS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tsa_pkg::map_access_type rd,
   input  tsa_pkg::map_access_type wr,
   input  logic [WIDTH-1:0]        wr_data,
   output logic [WIDTH-1:0]        rd_data
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;
   logic [DEPTH-1:0] valid_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[AW-1:0]] <= wr_data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr[AW-1:0]] <= 1'b1;
         end
         if (rd.en) begin
            rd_valid_ff <= valid_ff[rd.addr[AW-1:0]];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== hw/rtl/track_sector_allocator.sv =====
// ----------------------------------------------------------------------------
// track_sector_allocator
// Sector status map with first-block and next-block allocation around the
// directory track.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+--------------------------------------
//   req     | in  | req_tvalid/tready   | tuser func, tdata track/sector/status
//   rsp     | out | rsp_tvalid/tready   | tuser found, tdata out_track/sector
//   csr     | in  | csr_valid/ready     | csr_index, csr_wdata
//
// one item at a time; a status write goes through the start, check and result
// steps, an allocation probes one track per check step and adds a pass step
// for each new search pass; each probe is one read of the map memory
// reset is synchronous and leaves every sector free through per-track valid bits
// a new item is taken while the previous result still waits on rsp
// csr_ready is always high
//
module track_sector_allocator #(
   parameter int MAX_TRACKS  = tsa_pkg::MAX_TRACKS_DEFAULT,
   parameter int MAX_SECTORS = tsa_pkg::MAX_SECTORS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] func
   input  logic [15:0] req_tdata,   // [5:0] track, [10:6] sector, [12:11] status
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tuser,   // [0] found
   output logic [15:0] rsp_tdata,   // [5:0] out_track, [10:6] out_sector
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_wdata
);

   localparam int TW     = tsa_pkg::TRACK_W;
   localparam int SW     = tsa_pkg::SECTOR_W;
   localparam int CW     = tsa_pkg::CODE_W;
   localparam int WORD_W = CW * MAX_SECTORS;
   localparam int DEPTH  = MAX_TRACKS + 1;

   // configuration
   logic [tsa_pkg::IL_W-1:0] interleave_ff;
   logic                     consider_rsv_ff;
   logic [TW-1:0]            track_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         interleave_ff   <= tsa_pkg::INTERLEAVE_RESET;
         consider_rsv_ff <= tsa_pkg::CONSIDER_RSV_RESET;
         track_count_ff  <= tsa_pkg::TRACK_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tsa_pkg::REG_INTERLEAVE:   interleave_ff   <= csr_wdata[tsa_pkg::IL_W-1:0];
            tsa_pkg::REG_CONSIDER_RSV: consider_rsv_ff <= csr_wdata[0];
            tsa_pkg::REG_TRACK_COUNT:  track_count_ff  <= csr_wdata[TW-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // control and item registers
   tsa_pkg::tsa_state_type state_ff, state_in;

   logic [tsa_pkg::FUNC_W-1:0]   func_ff, func_in;
   logic [TW-1:0]                trk_ff, trk_in;
   logic [SW-1:0]                sec_ff, sec_in;
   logic [tsa_pkg::STATUS_W-1:0] st_ff, st_in;
   logic [TW-1:0]                cur_ff, cur_in;
   logic                         upper_ff, upper_in;
   logic [tsa_pkg::PASS_W-1:0]   pass_ff, pass_in;
   logic [MAX_SECTORS-1:0]       avail_ff, avail_in;
   logic [SW-1:0]                start_ff, start_in;
   logic                         res_found_ff, res_found_in;
   logic [TW-1:0]                res_track_ff, res_track_in;
   logic [SW-1:0]                res_sector_ff, res_sector_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic [TW-1:0]                rsp_track_ff, rsp_track_in;
   logic [SW-1:0]                rsp_sector_ff, rsp_sector_in;

   // memory interface
   tsa_pkg::map_access_type map_rd, map_wr;
   logic [WORD_W-1:0]       rd_word, wr_word;

   tsa_map_mem #(
      .DEPTH (DEPTH),
      .WIDTH (WORD_W)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .rd      (map_rd),
      .wr      (map_wr),
      .wr_data (wr_word),
      .rd_data (rd_word)
   );

   // search datapath
   logic                   req_acc;
   logic                   wr_ok;
   logic                   first_ok;
   logic                   upper0;
   logic                   pass_up;
   logic [TW-1:0]          pass_start;
   logic                   pass_ok;
   logic [TW-1:0]          nxt_track;
   logic                   nxt_ok;
   logic [SW-1:0]          cur_n;
   logic [MAX_SECTORS-1:0] avail;
   logic                   room;
   logic [SW-1:0]          start_calc;
   logic [SW-1:0]          pick;
   logic [SW-1:0]          wr_idx;
   logic [CW-1:0]          wr_code;

   assign req_acc = req_tvalid && req_tready;
   assign upper0  = trk_ff > tsa_pkg::DIR_TRACK;

   always_comb begin
      logic [TW-1:0] base, two_n, r1, r2;
      logic [CW-1:0] code;
      logic          hi_found;
      logic [SW-1:0] pick_hi, pick_lo;

      wr_ok = (st_ff <= tsa_pkg::STATUS_RESERVED)
              && tsa_pkg::track_exists(trk_ff, track_count_ff, MAX_TRACKS)
              && (sec_ff < tsa_pkg::sectors_on(trk_ff, MAX_SECTORS));
      first_ok = tsa_pkg::track_exists(tsa_pkg::DIR_TRACK, track_count_ff, MAX_TRACKS);

      // start of the current pass of a next-block search
      pass_up    = (pass_ff == tsa_pkg::PASS_OTHER) ? !upper0 : upper0;
      if (pass_ff == tsa_pkg::PASS_NEAR) begin
         pass_start = trk_ff;
      end else begin
         pass_start = pass_up ? tsa_pkg::UPPER_FIRST : tsa_pkg::DIR_TRACK;
      end
      pass_ok = tsa_pkg::track_exists(pass_start, track_count_ff, MAX_TRACKS);

      // track probed after the current one
      if (func_ff == tsa_pkg::FUNC_FIRST) begin
         if (cur_ff < tsa_pkg::DIR_TRACK) begin
            nxt_track = tsa_pkg::MIRROR_SUM - cur_ff;
         end else if (cur_ff <= tsa_pkg::MIRROR_LAST) begin
            nxt_track = tsa_pkg::MIRROR_NEXT - cur_ff;
         end else begin
            nxt_track = cur_ff + TW'(1);
         end
      end else begin
         nxt_track = upper_ff ? cur_ff + TW'(1) : cur_ff - TW'(1);
      end
      nxt_ok = tsa_pkg::track_exists(nxt_track, track_count_ff, MAX_TRACKS);

      // available sectors of the word just read
      cur_n = tsa_pkg::sectors_on(cur_ff, MAX_SECTORS);
      for (int s = 0; s < MAX_SECTORS; s++) begin
         code = rd_word[CW*s +: CW];
         avail[s] = (SW'(s) < cur_n)
                    && ((code == tsa_pkg::STATUS_FREE)
                        || ((code == tsa_pkg::STATUS_RESERVED) && !consider_rsv_ff));
      end
      room = |avail;

      // start sector: base is below four times the sector count
      base  = {1'b0, sec_ff};
      if ((func_ff == tsa_pkg::FUNC_NEXT) && (pass_ff == tsa_pkg::PASS_NEAR)) begin
         base = base + {1'b0, interleave_ff};
      end
      two_n = {cur_n, 1'b0};
      r1    = (base >= two_n) ? base - two_n : base;
      r2    = (r1 >= {1'b0, cur_n}) ? r1 - {1'b0, cur_n} : r1;
      start_calc = (func_ff == tsa_pkg::FUNC_FIRST) ? '0 : r2[SW-1:0];

      // first available sector from start, wrapping
      hi_found = 1'b0;
      pick_hi  = '0;
      pick_lo  = '0;
      for (int s = MAX_SECTORS - 1; s >= 0; s--) begin
         if (avail_ff[s]) begin
            pick_lo = SW'(s);
            if (SW'(s) >= start_ff) begin
               pick_hi  = SW'(s);
               hi_found = 1'b1;
            end
         end
      end
      pick = hi_found ? pick_hi : pick_lo;

      // read-modify-write of one sector code
      wr_idx  = (state_ff == tsa_pkg::ST_TAKE) ? pick : sec_ff;
      wr_code = (state_ff == tsa_pkg::ST_TAKE) ? tsa_pkg::STATUS_USED : st_ff;
      wr_word = rd_word;
      for (int s = 0; s < MAX_SECTORS; s++) begin
         if (SW'(s) == wr_idx) begin
            wr_word[CW*s +: CW] = wr_code;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tsa_pkg::ST_IDLE: begin
            if (req_acc) begin
               state_in = tsa_pkg::ST_START;
            end
         end
         tsa_pkg::ST_START: begin
            case (func_ff)
               tsa_pkg::FUNC_WRITE: state_in = wr_ok ? tsa_pkg::ST_CHECK : tsa_pkg::ST_RESULT;
               tsa_pkg::FUNC_FIRST: state_in = first_ok ? tsa_pkg::ST_CHECK : tsa_pkg::ST_RESULT;
               tsa_pkg::FUNC_NEXT:  state_in = tsa_pkg::ST_PASS;
               default:             state_in = tsa_pkg::ST_RESULT;
            endcase
         end
         tsa_pkg::ST_PASS: begin
            if (pass_ok) begin
               state_in = tsa_pkg::ST_CHECK;
            end else if (pass_ff == tsa_pkg::PASS_LAST) begin
               state_in = tsa_pkg::ST_RESULT;
            end
         end
         tsa_pkg::ST_CHECK: begin
            if (func_ff == tsa_pkg::FUNC_WRITE) begin
               state_in = tsa_pkg::ST_RESULT;
            end else if (room) begin
               state_in = tsa_pkg::ST_TAKE;
            end else if (nxt_ok) begin
               state_in = tsa_pkg::ST_CHECK;
            end else if ((func_ff == tsa_pkg::FUNC_NEXT) && (pass_ff != tsa_pkg::PASS_LAST)) begin
               state_in = tsa_pkg::ST_PASS;
            end else begin
               state_in = tsa_pkg::ST_RESULT;
            end
         end
         tsa_pkg::ST_TAKE: begin
            state_in = tsa_pkg::ST_RESULT;
         end
         tsa_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = tsa_pkg::ST_IDLE;
            end
         end
         default: state_in = tsa_pkg::ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_tready  = (state_ff == tsa_pkg::ST_IDLE);
      map_rd.en   = 1'b0;
      map_rd.addr = cur_ff;
      map_wr.en   = 1'b0;
      map_wr.addr = cur_ff;
      case (state_ff)
         tsa_pkg::ST_START: begin
            if (func_ff == tsa_pkg::FUNC_WRITE) begin
               map_rd.en   = wr_ok;
               map_rd.addr = trk_ff;
            end else if (func_ff == tsa_pkg::FUNC_FIRST) begin
               map_rd.en   = first_ok;
               map_rd.addr = tsa_pkg::DIR_TRACK;
            end
         end
         tsa_pkg::ST_PASS: begin
            map_rd.en   = pass_ok;
            map_rd.addr = pass_start;
         end
         tsa_pkg::ST_CHECK: begin
            if (func_ff == tsa_pkg::FUNC_WRITE) begin
               map_wr.en = 1'b1;
            end else if (!room) begin
               map_rd.en   = nxt_ok;
               map_rd.addr = nxt_track;
            end
         end
         tsa_pkg::ST_TAKE: begin
            map_wr.en = 1'b1;
         end
         default: ;
      endcase
   end

   // datapath register next values
   always_comb begin
      func_in       = func_ff;
      trk_in        = trk_ff;
      sec_in        = sec_ff;
      st_in         = st_ff;
      cur_in        = cur_ff;
      upper_in      = upper_ff;
      pass_in       = pass_ff;
      avail_in      = avail_ff;
      start_in      = start_ff;
      res_found_in  = res_found_ff;
      res_track_in  = res_track_ff;
      res_sector_in = res_sector_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_found_in  = rsp_found_ff;
      rsp_track_in  = rsp_track_ff;
      rsp_sector_in = rsp_sector_ff;

      case (state_ff)
         tsa_pkg::ST_IDLE: begin
            if (req_acc) begin
               func_in       = req_tuser;
               trk_in        = req_tdata[5:0];
               sec_in        = req_tdata[10:6];
               st_in         = req_tdata[12:11];
               pass_in       = tsa_pkg::PASS_NEAR;
               res_found_in  = 1'b0;
               res_track_in  = '0;
               res_sector_in = '0;
            end
         end
         tsa_pkg::ST_START: begin
            if (func_ff == tsa_pkg::FUNC_WRITE) begin
               cur_in = trk_ff;
            end else begin
               cur_in = tsa_pkg::DIR_TRACK;
            end
         end
         tsa_pkg::ST_PASS: begin
            if (pass_ok) begin
               cur_in   = pass_start;
               upper_in = pass_up;
            end else if (pass_ff != tsa_pkg::PASS_LAST) begin
               pass_in = pass_ff + tsa_pkg::PASS_W'(1);
            end
         end
         tsa_pkg::ST_CHECK: begin
            avail_in = avail;
            start_in = start_calc;
            if (func_ff == tsa_pkg::FUNC_WRITE) begin
               res_found_in  = 1'b1;
               res_track_in  = trk_ff;
               res_sector_in = sec_ff;
            end else if (!room) begin
               if (nxt_ok) begin
                  cur_in = nxt_track;
               end else if (pass_ff != tsa_pkg::PASS_LAST) begin
                  pass_in = pass_ff + tsa_pkg::PASS_W'(1);
               end
            end
         end
         tsa_pkg::ST_TAKE: begin
            res_found_in  = 1'b1;
            res_track_in  = cur_ff;
            res_sector_in = pick;
         end
         tsa_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = res_found_ff;
               rsp_track_in  = res_track_ff;
               rsp_sector_in = res_sector_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      trk_ff        <= trk_in;
      sec_ff        <= sec_in;
      st_ff         <= st_in;
      cur_ff        <= cur_in;
      upper_ff      <= upper_in;
      pass_ff       <= pass_in;
      avail_ff      <= avail_in;
      start_ff      <= start_in;
      res_found_ff  <= res_found_in;
      res_track_ff  <= res_track_in;
      res_sector_ff <= res_sector_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_track_ff  <= rsp_track_in;
      rsp_sector_ff <= rsp_sector_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {5'b0, rsp_sector_ff, rsp_track_ff};

   // the map is only written by a status write or by taking a sector
   a_write_states: assert property (@(posedge clock) disable iff (reset)
      map_wr.en |-> (state_ff == tsa_pkg::ST_CHECK) || (state_ff == tsa_pkg::ST_TAKE))
      else $error("map written outside a write or take step");

   // a sector is only taken from a track that had room
   a_take_has_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tsa_pkg::ST_TAKE) |-> (avail_ff != '0))
      else $error("take step on a full track");

   // an accepted item starts its work in the next cycle
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == tsa_pkg::ST_START))
      else $error("accepted item did not start");

   // a new result only appears out of the result step
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == tsa_pkg::ST_RESULT))
      else $error("result raised outside the result step");

   // a live result that is not found carries track and sector zero
   a_found_track: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_track_ff == '0) && (rsp_sector_ff == '0))
      else $error("failed result carries a position");

endmodule
